@@ sv/segment_docid_remapper_assert.svh @@
// Assertion macros shared by the segment id remapper RTL
`ifndef SEGMENT_DOCID_REMAPPER_ASSERT_SVH
`define SEGMENT_DOCID_REMAPPER_ASSERT_SVH
`ifndef SYNTHESIS
// checked on every clock edge once reset is released
`define SDR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define SDR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDR_ASSERT(lbl, prop, msg)
`define SDR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ sv/sdr_pkg.sv @@
// Types and constants shared by the segment id remapper
`default_nettype none
package sdr_pkg;

    localparam int MAX_SOURCE_SEGMENTS_DEF = 16;
    localparam int MAX_TARGET_SEGMENTS_DEF = 16;

    localparam int SEG_W     = 16;
    localparam int ID_W      = 32;
    localparam int SLOT_W    = 4;
    localparam int CNT_REG_W = 5;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WR_SRC = 2'd0,
        OP_WR_TGT = 2'd1,
        OP_FWD    = 2'd2,
        OP_REV    = 2'd3
    } op_t;

    // register select, taken from paddr[2]
    localparam logic REG_SRC_COUNT = 1'b0;
    localparam logic REG_TGT_COUNT = 1'b1;

    typedef struct packed {
        op_t              op;
        logic [SLOT_W-1:0] slot;
        logic [SEG_W-1:0]  segment;
        logic [ID_W-1:0]   base;
        logic [ID_W-1:0]   count;
        logic [ID_W-1:0]   query;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } queue_out_t;

    typedef struct packed {
        logic [SEG_W-1:0] segment;
        logic [ID_W-1:0]  base;
        logic [ID_W-1:0]  count;
    } src_entry_t;

    typedef struct packed {
        logic [SEG_W-1:0] segment;
        logic [ID_W-1:0]  count;
    } tgt_entry_t;

endpackage
`default_nettype wire

@@ sv/sdr_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module sdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

@@ sv/sdr_front.sv @@
// Front end: request intake, slot range check and two-entry request queue
`default_nettype none
`include "segment_docid_remapper_assert.svh"
module sdr_front
    import sdr_pkg::*;
#(
    parameter int SRC_DEPTH = MAX_SOURCE_SEGMENTS_DEF,
    parameter int TGT_DEPTH = MAX_TARGET_SEGMENTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [SEG_W-1:0]  entry_segment,
    input  wire logic [ID_W-1:0]   entry_base,
    input  wire logic [ID_W-1:0]   entry_count,
    input  wire logic [ID_W-1:0]   query_id,
    output logic                   busy,
    output queue_out_t             deq,
    input  wire logic              pop
);

    req_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       keep;
    logic       push;
    req_t       new_req;

    // writes to slots outside the table are accepted and dropped here
    always_comb
    begin
        case (op_t'(op))
            OP_WR_SRC: keep = (32'(slot) < 32'(SRC_DEPTH));
            OP_WR_TGT: keep = (32'(slot) < 32'(TGT_DEPTH));
            default:   keep = 1'b1;
        endcase
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start & ~busy & keep;

    always_comb
    begin
        new_req.op      = op_t'(op);
        new_req.slot    = slot;
        new_req.segment = entry_segment;
        new_req.base    = entry_base;
        new_req.count   = entry_count;
        new_req.query   = query_id;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_req;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign deq.valid = (cnt_reg != 2'd0);
    assign deq.req   = mem_reg[rd_ptr_reg];

    `SDR_ASSERT_RST(a_cnt_range, cnt_reg != 2'd3, "queue count out of range")
    `SDR_ASSERT(a_pop_nonempty, pop |-> (cnt_reg != 2'd0), "pop from empty queue")
    `SDR_ASSERT(a_ptr_match, (cnt_reg != 2'd1) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointer skew")

endmodule
`default_nettype wire

@@ sv/sdr_back.sv @@
// Back end: segment tables and the sequential source/target table walker
`default_nettype none
`include "segment_docid_remapper_assert.svh"
module sdr_back
    import sdr_pkg::*;
#(
    parameter int SRC_DEPTH = MAX_SOURCE_SEGMENTS_DEF,
    parameter int TGT_DEPTH = MAX_TARGET_SEGMENTS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire queue_out_t           deq,
    output logic                      pop,
    input  wire logic [CNT_REG_W-1:0] src_count,
    input  wire logic [CNT_REG_W-1:0] tgt_count,
    output logic                      done,
    output logic                      found,
    output logic [SEG_W-1:0]          result_segment,
    output logic [ID_W-1:0]           local_id,
    output logic [ID_W-1:0]           merged_id
);

    localparam int MAXD  = (SRC_DEPTH > TGT_DEPTH) ? SRC_DEPTH : TGT_DEPTH;
    localparam int IDX_W = $clog2(MAXD + 1);
    localparam int CMP_W = (IDX_W > CNT_REG_W) ? IDX_W : CNT_REG_W;
    localparam int SAW   = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
    localparam int TAW   = (TGT_DEPTH > 1) ? $clog2(TGT_DEPTH) : 1;
    // running sum of up to SRC_DEPTH counts plus one partial count
    localparam int ACC_W = ID_W + 1 + $clog2(SRC_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SRC  = 3'b010,
        ST_TGT  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ID_W-1:0]   q_reg, q_next;
    logic              fwd_reg, fwd_next;
    logic [ID_W-1:0]   merged_reg, merged_next;
    logic              done_reg;
    logic              found_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic [ID_W-1:0]   local_reg;
    logic [ID_W-1:0]   mout_reg;

    logic              src_we, tgt_we;
    src_entry_t        src_wr, src_rd;
    tgt_entry_t        tgt_wr, tgt_rd;

    logic              emit, e_found;
    logic [SEG_W-1:0]  e_seg;
    logic [ID_W-1:0]   e_local, e_merged;

    logic [ID_W:0]     src_end;
    logic              fwd_in, fwd_below, rev_in, tgt_in;
    logic [ACC_W-1:0]  acc_hit, acc_add, acc_sub;
    logic              src_last, tgt_last, acc_fits;

    assign src_wr.segment = deq.req.segment;
    assign src_wr.base    = deq.req.base;
    assign src_wr.count   = deq.req.count;
    assign tgt_wr.segment = deq.req.segment;
    assign tgt_wr.count   = deq.req.count;

    // read address follows idx_next so read data always belongs to idx_reg
    sdr_ram #(.WIDTH($bits(src_entry_t)), .DEPTH(SRC_DEPTH)) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (SAW'(deq.req.slot)),
        .wdata (src_wr),
        .raddr (idx_next[SAW-1:0]),
        .rdata (src_rd)
    );

    sdr_ram #(.WIDTH($bits(tgt_entry_t)), .DEPTH(TGT_DEPTH)) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (TAW'(deq.req.slot)),
        .wdata (tgt_wr),
        .raddr (idx_next[TAW-1:0]),
        .rdata (tgt_rd)
    );

    assign src_end   = {1'b0, src_rd.base} + {1'b0, src_rd.count};
    assign fwd_in    = (q_reg >= src_rd.base) && (src_end > {1'b0, q_reg});
    assign fwd_below = (src_end <= {1'b0, q_reg});
    assign acc_hit   = acc_reg + ACC_W'(q_reg - src_rd.base);
    assign acc_add   = acc_reg + ACC_W'(src_rd.count);
    assign rev_in    = (ACC_W'(q_reg) < acc_add);
    assign tgt_in    = (acc_reg < ACC_W'(tgt_rd.count));
    assign acc_sub   = acc_reg - ACC_W'(tgt_rd.count);
    assign acc_fits  = ((acc_reg >> ID_W) == '0);

    // a count register above the table depth is clipped to the depth
    assign src_last = (CMP_W'(idx_reg) >= CMP_W'(src_count)) ||
                      (idx_reg == IDX_W'(SRC_DEPTH));
    assign tgt_last = (CMP_W'(idx_reg) >= CMP_W'(tgt_count)) ||
                      (idx_reg == IDX_W'(TGT_DEPTH));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        q_next      = q_reg;
        fwd_next    = fwd_reg;
        merged_next = merged_reg;
        pop         = 1'b0;
        src_we      = 1'b0;
        tgt_we      = 1'b0;
        emit        = 1'b0;
        e_found     = 1'b0;
        e_seg       = '0;
        e_local     = '0;
        e_merged    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (deq.valid)
                begin
                    pop = 1'b1;
                    case (deq.req.op)
                        OP_WR_SRC: src_we = 1'b1;
                        OP_WR_TGT: tgt_we = 1'b1;
                        default:
                        begin
                            q_next     = deq.req.query;
                            fwd_next   = (deq.req.op == OP_FWD);
                            acc_next   = '0;
                            idx_next   = '0;
                            state_next = ST_SRC;
                        end
                    endcase
                end
            end
            ST_SRC:
            begin
                if (src_last)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (fwd_reg)
                begin
                    if (fwd_in)
                    begin
                        acc_next    = acc_hit;
                        merged_next = acc_hit[ID_W-1:0];
                        idx_next    = '0;
                        state_next  = ST_TGT;
                    end
                    else if (fwd_below)
                    begin
                        acc_next = acc_add;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        // id lies in a gap below this segment
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if (rev_in)
                    begin
                        emit       = 1'b1;
                        e_found    = 1'b1;
                        e_seg      = src_rd.segment;
                        e_local    = q_reg - acc_reg[ID_W-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        acc_next = acc_add;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_TGT:
            begin
                if (!acc_fits)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    e_merged = merged_reg;
                    if (tgt_last)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (tgt_in)
                    begin
                        emit       = 1'b1;
                        e_found    = 1'b1;
                        e_seg      = tgt_rd.segment;
                        e_local    = acc_reg[ID_W-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        acc_next = acc_sub;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        q_reg      <= q_next;
        fwd_reg    <= fwd_next;
        merged_reg <= merged_next;
        if (emit)
        begin
            found_reg <= e_found;
            seg_reg   <= e_seg;
            local_reg <= e_local;
            mout_reg  <= e_merged;
        end
    end

    assign done           = done_reg;
    assign found          = found_reg;
    assign result_segment = seg_reg;
    assign local_id       = local_reg;
    assign merged_id      = mout_reg;

    `SDR_ASSERT(a_done_pulse, done_reg |=> !done_reg, "result strobe longer than one cycle")
    `SDR_ASSERT(a_tgt_fwd, (state_reg == ST_TGT) |-> fwd_reg, "target walk on reverse query")
    `SDR_ASSERT(a_idx_bound, idx_reg <= IDX_W'(MAXD), "walk index past table depth")

endmodule
`default_nettype wire

@@ sv/segment_docid_remapper.sv @@
// Top level of the segment id remapper: config registers, front end, back end
//
//  - Requests enter on start/busy: a request is taken at a clock edge where
//    start is high and busy is low. op selects a source table write, a
//    target table write, a forward map (old global id to target segment)
//    or a reverse map (merged id to source segment).
//  - Table writes give no result. Each map request gives exactly one
//    result: done is high for one cycle with found, result_segment,
//    local_id and merged_id valid in that cycle. The receiver cannot stall.
//  - A map request is popped from the queue into the walker, which reads
//    source entries one at a time and, for a forward hit, then target
//    entries; the result is registered from the last step. Reverse maps
//    and source misses skip the target walk.
//  - A two-entry request queue sits between intake and walker; busy is high
//    while it is full. Writes drain one per cycle when the walker is idle.
//  - Entry counts are set over APB: source count at 0x0, target count at
//    0x4. Change them only while the block is idle.
//  - Reset clears the count registers and the queue; table contents are
//    not cleared and must be written before use.
`default_nettype none
module segment_docid_remapper
    import sdr_pkg::*;
#(
    parameter int MAX_SOURCE_SEGMENTS = MAX_SOURCE_SEGMENTS_DEF,
    parameter int MAX_TARGET_SEGMENTS = MAX_TARGET_SEGMENTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // APB configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // request channel
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [SEG_W-1:0]  entry_segment,
    input  wire logic [ID_W-1:0]   entry_base,
    input  wire logic [ID_W-1:0]   entry_count,
    input  wire logic [ID_W-1:0]   query_id,
    // result channel
    output logic                   done,
    output logic                   found,
    output logic [SEG_W-1:0]       result_segment,
    output logic [ID_W-1:0]        local_id,
    output logic [ID_W-1:0]        merged_id
);

    logic [CNT_REG_W-1:0] src_count_reg, src_count_next;
    logic [CNT_REG_W-1:0] tgt_count_reg, tgt_count_next;
    logic                 cfg_wr;
    queue_out_t           deq;
    logic                 pop;

    // register interface: no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        src_count_next = src_count_reg;
        tgt_count_next = tgt_count_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_SRC_COUNT: src_count_next = pwdata[CNT_REG_W-1:0];
                REG_TGT_COUNT: tgt_count_next = pwdata[CNT_REG_W-1:0];
                default:       src_count_next = src_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SRC_COUNT: prdata = 32'(src_count_reg);
            REG_TGT_COUNT: prdata = 32'(tgt_count_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_count_reg <= '0;
            tgt_count_reg <= '0;
        end
        else
        begin
            src_count_reg <= src_count_next;
            tgt_count_reg <= tgt_count_next;
        end
    end

    // intake and request queue
    sdr_front #(
        .SRC_DEPTH (MAX_SOURCE_SEGMENTS),
        .TGT_DEPTH (MAX_TARGET_SEGMENTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .op            (op),
        .slot          (slot),
        .entry_segment (entry_segment),
        .entry_base    (entry_base),
        .entry_count   (entry_count),
        .query_id      (query_id),
        .busy          (busy),
        .deq           (deq),
        .pop           (pop)
    );

    // tables and walker
    sdr_back #(
        .SRC_DEPTH (MAX_SOURCE_SEGMENTS),
        .TGT_DEPTH (MAX_TARGET_SEGMENTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .deq            (deq),
        .pop            (pop),
        .src_count      (src_count_reg),
        .tgt_count      (tgt_count_reg),
        .done           (done),
        .found          (found),
        .result_segment (result_segment),
        .local_id       (local_id),
        .merged_id      (merged_id)
    );

endmodule
`default_nettype wire

@@ test/segment_docid_remapper_tb.sv @@
// Self-checking testbench for segment_docid_remapper: table loads, forward and reverse maps
`default_nettype none
module segment_docid_remapper_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sdr_pkg::*;

    localparam int TBL_DEPTH   = 16;
    // covers the longest map plus up to two queued table writes
    localparam int DRAIN_CYCLES = 40;
    // cycles with neither a request nor a result taken before giving up
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 40;
    localparam int PRINT_CAP   = 50;

    typedef struct packed {
        logic             found;
        logic [SEG_W-1:0] segment;
        logic [ID_W-1:0]  loc;
        logic [ID_W-1:0]  merged;
    } map_result_t;

    // Mirror of both segment tables and count registers, plus the queue of
    // map results still owed by the block.
    class docid_remap_board;
        logic [SEG_W-1:0]     src_seg  [TBL_DEPTH];
        logic [ID_W-1:0]      src_base [TBL_DEPTH];
        logic [ID_W-1:0]      src_cnt  [TBL_DEPTH];
        logic [SEG_W-1:0]     tgt_seg  [TBL_DEPTH];
        logic [ID_W-1:0]      tgt_cnt  [TBL_DEPTH];
        logic [CNT_REG_W-1:0] src_used;
        logic [CNT_REG_W-1:0] tgt_used;
        map_result_t          pending_maps [$];
        int                   mismatches;

        function new();
            src_used   = '0;
            tgt_used   = '0;
            mismatches = 0;
        endfunction

        function void write_count_reg(logic sel, logic [31:0] value);
            if (sel == REG_SRC_COUNT)
                src_used = value[CNT_REG_W-1:0];
            else
                tgt_used = value[CNT_REG_W-1:0];
        endfunction

        // counts above the table depth clamp to the depth
        function int walk_len(logic [CNT_REG_W-1:0] r);
            return (r > TBL_DEPTH) ? TBL_DEPTH : int'(r);
        endfunction

        function map_result_t map_forward(logic [ID_W-1:0] q);
            logic [63:0] acc;
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] q64;
            bit          hit;
            map_result_t r;
            r   = '0;
            acc = '0;
            hit = 0;
            q64 = {32'b0, q};
            for (int i = 0; i < walk_len(src_used); i++)
            begin
                lo = {32'b0, src_base[i]};
                hi = lo + {32'b0, src_cnt[i]};
                if (lo <= q64 && hi > q64)
                begin
                    acc = acc + (q64 - lo);
                    hit = 1;
                    break;
                end
                if (hi <= q64)
                    acc = acc + {32'b0, src_cnt[i]};
                else
                    break;  // id sits in a gap
            end
            if (hit && acc <= 64'h0000_0000_FFFF_FFFF)
            begin
                r.merged = acc[ID_W-1:0];
                for (int i = 0; i < walk_len(tgt_used); i++)
                begin
                    if (acc < {32'b0, tgt_cnt[i]})
                    begin
                        r.found   = 1'b1;
                        r.segment = tgt_seg[i];
                        r.loc     = acc[ID_W-1:0];
                        break;
                    end
                    acc = acc - {32'b0, tgt_cnt[i]};
                end
            end
            return r;
        endfunction

        function map_result_t map_reverse(logic [ID_W-1:0] q);
            logic [63:0] acc;
            logic [63:0] q64;
            map_result_t r;
            r   = '0;
            acc = '0;
            q64 = {32'b0, q};
            for (int i = 0; i < walk_len(src_used); i++)
            begin
                if (q64 >= acc && q64 < acc + {32'b0, src_cnt[i]})
                begin
                    r.found   = 1'b1;
                    r.segment = src_seg[i];
                    r.loc     = q - acc[ID_W-1:0];
                    break;
                end
                acc = acc + {32'b0, src_cnt[i]};
            end
            return r;
        endfunction

        function void note_request(op_t cmd, logic [SLOT_W-1:0] s, logic [SEG_W-1:0] seg,
                                   logic [ID_W-1:0] b, logic [ID_W-1:0] c,
                                   logic [ID_W-1:0] q);
            case (cmd)
                OP_WR_SRC:
                begin
                    src_seg[s]  = seg;
                    src_base[s] = b;
                    src_cnt[s]  = c;
                end
                OP_WR_TGT:
                begin
                    tgt_seg[s] = seg;
                    tgt_cnt[s] = c;
                end
                OP_FWD:  pending_maps.push_back(map_forward(q));
                default: pending_maps.push_back(map_reverse(q));
            endcase
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] got);
            if (mismatches < PRINT_CAP)
                $display("%0t: %s expected %h actual %h", $time, what, want, got);
            mismatches++;
        endfunction

        function void check_result(map_result_t got);
            map_result_t want;
            if (pending_maps.size() == 0)
            begin
                report("result with no map outstanding", 'x,
                       {15'b0, got.found, got.segment, got.loc});
                return;
            end
            want = pending_maps.pop_front();
            if (got.found !== want.found)
                report("found", 64'(want.found), 64'(got.found));
            if (got.segment !== want.segment)
                report("result_segment", 64'(want.segment), 64'(got.segment));
            if (got.loc !== want.loc)
                report("local_id", 64'(want.loc), 64'(got.loc));
            if (got.merged !== want.merged)
                report("merged_id", 64'(want.merged), 64'(got.merged));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [SEG_W-1:0]  entry_segment;
    logic [ID_W-1:0]   entry_base;
    logic [ID_W-1:0]   entry_count;
    logic [ID_W-1:0]   query_id;
    logic              done;
    logic              found;
    logic [SEG_W-1:0]  result_segment;
    logic [ID_W-1:0]   local_id;
    logic [ID_W-1:0]   merged_id;

    docid_remap_board remap_board = new();
    int               stall_cycles = 0;

    segment_docid_remapper uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .slot           (slot),
        .entry_segment  (entry_segment),
        .entry_base     (entry_base),
        .entry_count    (entry_count),
        .query_id       (query_id),
        .done           (done),
        .found          (found),
        .result_segment (result_segment),
        .local_id       (local_id),
        .merged_id      (merged_id)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Outputs are read right after the edge, so they hold the values of the
    // cycle that the edge closes; all block state moves in the NBA region.
    always @(posedge clk)
    begin
        if (rst_n && done)
            remap_board.check_result({found, result_segment, local_id, merged_id});
    end

    // Watchdog: any taken request or delivered result resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Holds start high until the block takes the request. Does not drop
    // start afterwards, so back-to-back requests keep it high.
    task automatic send_request(op_t cmd, logic [SLOT_W-1:0] s, logic [SEG_W-1:0] seg,
                                logic [ID_W-1:0] b, logic [ID_W-1:0] c, logic [ID_W-1:0] q);
        start         <= 1'b1;
        op            <= cmd;
        slot          <= s;
        entry_segment <= seg;
        entry_base    <= b;
        entry_count   <= c;
        query_id      <= q;
        do
            @(posedge clk);
        while (busy);
        remap_board.note_request(cmd, s, seg, b, c, q);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles == 0)
            return;
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // mostly back to back, some short gaps, rare long ones
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 200);
    endfunction

    task automatic apb_write(logic sel, logic [4:0] value);
        logic [31:0] data;
        // upper bits are don't-care; the register keeps five bits
        data    = ($urandom & ~32'h1F) | {27'b0, value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        remap_board.write_count_reg(sel, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Registers only change with the block idle: every map answered, then
    // enough cycles for any queued table writes to retire.
    task automatic set_counts(logic [4:0] src_n, logic [4:0] tgt_n);
        start <= 1'b0;
        while (remap_board.pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_write(REG_SRC_COUNT, src_n);
        apb_write(REG_TGT_COUNT, tgt_n);
    endtask

    task automatic write_src(logic [SLOT_W-1:0] s, logic [SEG_W-1:0] seg,
                             logic [ID_W-1:0] b, logic [ID_W-1:0] c);
        send_request(OP_WR_SRC, s, seg, b, c, $urandom);
    endtask

    task automatic write_tgt(logic [SLOT_W-1:0] s, logic [SEG_W-1:0] seg, logic [ID_W-1:0] c);
        send_request(OP_WR_TGT, s, seg, $urandom, c, $urandom);
    endtask

    task automatic map_query(op_t cmd, logic [ID_W-1:0] q);
        send_request(cmd, SLOT_W'($urandom), SEG_W'($urandom), $urandom, $urandom, q);
    endtask

    // Layout styles: 0 small dense counts, 1 wide counts with ascending
    // bases, 2 fully random including the all-zero and all-one counts.
    function automatic logic [ID_W-1:0] pick_count(int mode);
        if (mode == 0)
            return $urandom_range(0, 40);
        if (mode == 1)
            return $urandom >> $urandom_range(2, 28);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_tgt_count(int mode);
        return (mode == 0) ? $urandom_range(0, 60) : pick_count(mode);
    endfunction

    function automatic logic [4:0] pick_count_reg(int phase, bit is_src);
        if (phase == 0)
            return 5'd16;
        if (phase == 1)
            return 5'd31;
        if (phase == 2)
            return is_src ? 5'd16 : 5'd0;
        case ($urandom_range(0, 7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd31;
            4:       return 5'($urandom_range(17, 30));
            default: return 5'($urandom_range(2, 15));
        endcase
    endfunction

    // Forward ids aim inside a source segment most of the time, else at
    // its edges, the gap below it, or anywhere.
    function automatic logic [ID_W-1:0] pick_forward_id();
        int              k;
        logic [ID_W-1:0] b;
        logic [ID_W-1:0] c;
        k = $urandom_range(0, TBL_DEPTH - 1);
        b = remap_board.src_base[k];
        c = remap_board.src_cnt[k];
        case ($urandom_range(0, 9))
            6:  return b - 1;
            7:  return b + c;
            8:  return b + c - 1;
            9:  return ($urandom_range(0, 1) != 0) ? $urandom : {ID_W{$urandom_range(0, 1) != 0}};
            default: return b + ((c == 0) ? '0 : $urandom % c);
        endcase
    endfunction

    // Reverse ids aim around the running sum of source counts.
    function automatic logic [ID_W-1:0] pick_reverse_id();
        int              k;
        logic [63:0]     prefix;
        logic [ID_W-1:0] c;
        k      = $urandom_range(0, TBL_DEPTH - 1);
        prefix = '0;
        for (int i = 0; i < k; i++)
            prefix = prefix + {32'b0, remap_board.src_cnt[i]};
        c = remap_board.src_cnt[k];
        case ($urandom_range(0, 9))
            6:  return prefix[ID_W-1:0] - 1;
            7:  return prefix[ID_W-1:0] + c;
            8:  return prefix[ID_W-1:0] + c - 1;
            9:  return $urandom;
            default: return prefix[ID_W-1:0] + ((c == 0) ? '0 : $urandom % c);
        endcase
    endfunction

    // Fills every slot of both tables, so no later walk reads a stale entry.
    task automatic load_layout(int mode, bit burst);
        logic [63:0]     next_base;
        logic [ID_W-1:0] cnt;
        next_base = 64'((mode == 0) ? $urandom_range(0, 50) : ($urandom >> $urandom_range(0, 31)));
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            cnt = pick_count(mode);
            write_src(SLOT_W'(i), SEG_W'($urandom),
                      (mode == 2) ? $urandom : next_base[ID_W-1:0], cnt);
            idle_gap(pick_gap(burst));
            next_base = next_base + cnt;
            if ($urandom_range(0, 1) != 0)
                next_base = next_base + ((mode == 0) ? $urandom_range(1, 3)
                                                     : ($urandom >> $urandom_range(4, 31)));
            write_tgt(SLOT_W'(i), SEG_W'($urandom), pick_tgt_count(mode));
            idle_gap(pick_gap(burst));
        end
    endtask

    task automatic random_item(int mode);
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, TBL_DEPTH - 1);
        if (r < 45)
            map_query(OP_FWD, pick_forward_id());
        else if (r < 85)
            map_query(OP_REV, pick_reverse_id());
        else if (r < 93)
            write_src(SLOT_W'(k), SEG_W'($urandom), remap_board.src_base[k], pick_count(mode));
        else
            write_tgt(SLOT_W'(k), SEG_W'($urandom), pick_tgt_count(mode));
    endtask

    initial
    begin
        int mode;
        bit burst;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        start         = 1'b0;
        op            = OP_WR_SRC;
        slot          = '0;
        entry_segment = '0;
        entry_base    = '0;
        entry_count   = '0;
        query_id      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: with both counts at reset value nothing is walked,
        // so every map misses.
        map_query(OP_FWD, 32'd100);
        map_query(OP_REV, 32'd0);

        // Three source segments (the last one running past 2^32), two
        // target segments.
        set_counts(5'd3, 5'd2);
        write_src(4'd0, 16'h0001, 32'd100, 32'd10);
        write_src(4'd1, 16'hFFFF, 32'd200, 32'd5);
        write_src(4'd15 & 4'd2, 16'h0000, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        write_tgt(4'd0, 16'h8000, 32'd12);
        write_tgt(4'd1, 16'h7FFF, 32'hFFFF_FFFF);
        map_query(OP_FWD, 32'd100);         // first id of first segment
        map_query(OP_FWD, 32'd109);         // last id of first segment
        map_query(OP_FWD, 32'd99);          // below the first base
        map_query(OP_FWD, 32'd150);         // gap between segments
        map_query(OP_FWD, 32'd202);         // crosses into second target
        map_query(OP_FWD, 32'hFFFF_FFFF);   // top id, sum must not wrap
        map_query(OP_FWD, 32'd0);
        map_query(OP_REV, 32'd0);
        map_query(OP_REV, 32'd14);
        map_query(OP_REV, 32'd15);
        map_query(OP_REV, 32'hFFFF_FFFF);

        // Overlapping full-range segments push the merged id past 32 bits.
        write_src(4'd0, 16'h1234, 32'd0, 32'hFFFF_FFFF);
        write_src(4'd1, 16'hABCD, 32'd0, 32'hFFFF_FFFF);
        write_src(4'd2, 16'h5555, 32'h8000_0000, 32'hFFFF_FFFF);
        map_query(OP_FWD, 32'hFFFF_FFFF);   // merged id too wide: miss
        map_query(OP_FWD, 32'h8000_0000);   // hits in the first segment

        // Random phases: new counts, a full table load, then a mix of
        // maps and single-entry rewrites. Some phases run without gaps.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            mode  = phase % 3;
            burst = ($urandom_range(0, 3) == 0);
            set_counts(pick_count_reg(phase, 1'b1), pick_count_reg(phase, 1'b0));
            load_layout(mode, burst);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_item(mode);
                idle_gap(pick_gap(burst));
            end
        end

        start <= 1'b0;
        while (remap_board.pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (remap_board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/sdr_pkg.sv
sv/sdr_ram.sv
sv/sdr_front.sv
sv/sdr_back.sv
sv/segment_docid_remapper.sv
test/segment_docid_remapper_tb.sv
